// ===== hw/rtl/gre_pkg.sv =====
// Package for the grid ray wall traversal block.
// Holds shared field widths, command and register codes and the controller state type.
// No dependencies.
package gre_pkg;

  localparam int DIR_W  = 19;
  localparam int ORG_W  = 22;
  localparam int DIST_W = 24;
  localparam int TILE_W = 6;
  localparam int CFG_W  = 7;
  // signed cell coordinate width: origin integer part plus the longest walk
  localparam int CW     = 24;

  localparam logic [DIST_W-1:0] SAT_DIST = 24'hFFFFFF;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_ORG,
    ST_STEP,
    ST_LOOK
  } gre_state_t;

endpackage

// ===== hw/rtl/gre_row_mem.sv =====
// Wall map storage: one row of tiles per word, one read and one write port.
// Read data is registered and holds until the next read. Uses gre_pkg nothing.
module gre_row_mem #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [$clog2(ROWS)-1:0] rd_addr,
  output logic [COLS-1:0]         rd_data,
  input  logic                    wr_en,
  input  logic [$clog2(ROWS)-1:0] wr_addr,
  input  logic [COLS-1:0]         wr_data
);

  logic [COLS-1:0] mem [ROWS];
  logic [COLS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/gre_div.sv =====
// Restoring divider, one quotient bit per cycle, for the ray delta and first crossing.
// Divisor width follows the direction field of gre_pkg.
module gre_div #(
  parameter int DW = 33
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DW-1:0]           dividend,
  input  logic [gre_pkg::DIR_W-1:0] divisor,
  output logic                    done,
  output logic [DW-1:0]           quotient
);

  localparam int RW  = gre_pkg::DIR_W + 1;
  localparam int CNW = $clog2(DW + 1);

  logic [DW-1:0]  quo_r, quo_nxt;
  logic [RW-1:0]  rem_r, rem_nxt;
  logic [gre_pkg::DIR_W-1:0] div_r, div_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           run_r, run_nxt;
  logic           done_r, done_nxt;
  logic [RW-1:0]  trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r[RW-2:0], quo_r[DW-1]};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
      cnt_nxt = CNW'(DW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = trial - {1'b0, div_r};
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/grid_ray_wall_traversal.sv =====
// Grid ray caster over a one-bit wall map; top level with controller and step datapath.
// Uses gre_pkg, gre_row_mem (wall map rows) and gre_div (shared divider).
//
// Usage:
//  - Command channel: an item is taken at a clock edge with start high and busy low.
//    in_command selects a tile write (no result) or a ray cast (one result).
//  - Result channel: out_valid is high for one cycle with out_hit_distance, Q8.16,
//    saturated to all ones. The receiver cannot stall; the result is simply taken.
//  - Configuration: cfg_valid/cfg_ready write map_width (index 0) or map_height
//    (index 1); cfg_ready is always high. Write only while busy is low.
//  - Reset: the map is cleared one row per cycle, with busy high.
//  - Tile write: row read, then modified row written back.
//  - Cast: four divisions, each launched and then run to 2*FRAC_BITS+1 quotient bits
//    and a done, then an origin cell check, then for each cell step a step with map
//    row read followed by a hit check, and a finish that registers the result.
//    The divider is shared and the map has a single read port.
//  - One item at a time; busy stays high until its result is shown.
module grid_ray_wall_traversal #(
  parameter int MAP_DIM   = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_command,
  input  logic [gre_pkg::TILE_W-1:0]       in_tile_x,
  input  logic [gre_pkg::TILE_W-1:0]       in_tile_y,
  input  logic                             in_tile_wall,
  input  logic [gre_pkg::ORG_W-1:0]        in_origin_x,
  input  logic [gre_pkg::ORG_W-1:0]        in_origin_y,
  input  logic signed [gre_pkg::DIR_W-1:0] in_dir_x,
  input  logic signed [gre_pkg::DIR_W-1:0] in_dir_y,
  input  logic [gre_pkg::DIST_W-1:0]       in_min_distance,
  output logic                             out_valid,
  output logic [gre_pkg::DIST_W-1:0]       out_hit_distance,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [gre_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AW  = $clog2(MAP_DIM);
  localparam int F   = FRAC_BITS;
  localparam int DW  = 2 * F + 1;
  localparam int TW  = (2 * F + 2 > 25) ? 2 * F + 2 : 25;
  localparam int CW  = gre_pkg::CW;
  localparam int OEW = gre_pkg::ORG_W + F;
  localparam int DRW = gre_pkg::DIR_W;

  gre_pkg::gre_state_t state_r, state_nxt;

  logic [AW-1:0]               clr_row_r, clr_row_nxt;
  logic [gre_pkg::CFG_W-1:0]   map_w_r, map_h_r;
  logic [AW-1:0]               wx_r, wx_nxt, wy_r, wy_nxt;
  logic                        wwall_r, wwall_nxt;
  logic signed [CW-1:0]        ix_r, ix_nxt, iy_r, iy_nxt;
  logic [F-1:0]                fx_r, fx_nxt, fy_r, fy_nxt;
  logic [DRW-1:0]              magx_r, magx_nxt, magy_r, magy_nxt;
  logic                        xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic                        xzero_r, xzero_nxt, yzero_r, yzero_nxt;
  logic [TW-1:0]               dx_r, dx_nxt, dy_r, dy_nxt;
  logic [TW-1:0]               tx_r, tx_nxt, ty_r, ty_nxt;
  logic [TW-1:0]               m_r, m_nxt;
  logic                        xax_r, xax_nxt;
  logic [gre_pkg::DIST_W-1:0]  limit_r, limit_nxt;
  logic [1:0]                  phase_r, phase_nxt;
  logic                        prevblk_r, prevblk_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [gre_pkg::DIST_W-1:0]  out_dist_r, out_dist_nxt;

  // map and divider ports
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [MAP_DIM-1:0]   rd_data, wr_data, row_mod;
  logic                 div_start, div_done;
  logic [DW-1:0]        div_dividend, div_q;
  logic [DRW-1:0]       div_divisor;

  // combinational helpers
  logic [CW-1:0]        effw, effh;
  logic [OEW-1:0]       oxe, oye;
  logic signed [CW-1:0] in_ix, in_iy, tile_xc, tile_yc;
  logic                 tile_out, cur_out, cur_blk;
  logic [F:0]           fxc, fyc;
  logic                 x_lt, sat, xaxis;
  logic [TW-1:0]        m_c;
  logic signed [CW-1:0] new_ix, new_iy;
  logic [TW-1:0]        q_ext;

  gre_row_mem #(.ROWS(MAP_DIM), .COLS(MAP_DIM)) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gre_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign effw = ({{(CW-gre_pkg::CFG_W){1'b0}}, map_w_r} > CW'(MAP_DIM)) ? CW'(MAP_DIM)
              : {{(CW-gre_pkg::CFG_W){1'b0}}, map_w_r};
  assign effh = ({{(CW-gre_pkg::CFG_W){1'b0}}, map_h_r} > CW'(MAP_DIM)) ? CW'(MAP_DIM)
              : {{(CW-gre_pkg::CFG_W){1'b0}}, map_h_r};

  assign oxe   = {{F{1'b0}}, in_origin_x};
  assign oye   = {{F{1'b0}}, in_origin_y};
  assign in_ix = {{(CW-gre_pkg::ORG_W){1'b0}}, oxe[OEW-1:F]};
  assign in_iy = {{(CW-gre_pkg::ORG_W){1'b0}}, oye[OEW-1:F]};

  assign tile_xc  = {{(CW-gre_pkg::TILE_W){1'b0}}, in_tile_x};
  assign tile_yc  = {{(CW-gre_pkg::TILE_W){1'b0}}, in_tile_y};
  assign tile_out = ($unsigned(tile_xc) >= effw) || ($unsigned(tile_yc) >= effh);

  assign cur_out = ix_r[CW-1] || iy_r[CW-1]
                || ($unsigned(ix_r) >= effw) || ($unsigned(iy_r) >= effh);
  assign cur_blk = cur_out || rd_data[ix_r[AW-1:0]];

  // distance from origin to the first boundary along each axis, in cell units
  assign fxc = xneg_r ? {1'b0, fx_r} : ({1'b1, {F{1'b0}}} - {1'b0, fx_r});
  assign fyc = yneg_r ? {1'b0, fy_r} : ({1'b1, {F{1'b0}}} - {1'b0, fy_r});

  // a zero direction axis has an infinite crossing parameter
  assign x_lt  = !xzero_r && (yzero_r || (tx_r < ty_r));
  assign m_c   = x_lt ? tx_r : ty_r;
  assign sat   = (xzero_r && yzero_r) || (m_c >= TW'(gre_pkg::SAT_DIST));
  assign xaxis = yzero_r || x_lt;
  assign new_ix = !xaxis ? ix_r : (xneg_r ? ix_r - CW'(1) : ix_r + CW'(1));
  assign new_iy = xaxis ? iy_r : (yneg_r ? iy_r - CW'(1) : iy_r + CW'(1));

  assign q_ext = {{(TW-DW){1'b0}}, div_q};

  always_comb begin
    row_mod = rd_data;
    row_mod[wx_r] = wwall_r;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_row_nxt   = clr_row_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    wwall_nxt     = wwall_r;
    ix_nxt        = ix_r;
    iy_nxt        = iy_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    magx_nxt      = magx_r;
    magy_nxt      = magy_r;
    xneg_nxt      = xneg_r;
    yneg_nxt      = yneg_r;
    xzero_nxt     = xzero_r;
    yzero_nxt     = yzero_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    m_nxt         = m_r;
    xax_nxt       = xax_r;
    limit_nxt     = limit_r;
    phase_nxt     = phase_r;
    prevblk_nxt   = prevblk_r;
    out_valid_nxt = 1'b0;
    out_dist_nxt  = out_dist_r;
    rd_en         = 1'b0;
    rd_addr       = iy_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = wy_r;
    wr_data       = row_mod;
    div_start     = 1'b0;
    unique case (phase_r)
      2'd0:    begin div_dividend = {1'b1, {(DW-1){1'b0}}}; div_divisor = magx_r; end
      2'd1:    begin div_dividend = {fxc, {F{1'b0}}};       div_divisor = magx_r; end
      2'd2:    begin div_dividend = {1'b1, {(DW-1){1'b0}}}; div_divisor = magy_r; end
      default: begin div_dividend = {fyc, {F{1'b0}}};       div_divisor = magy_r; end
    endcase

    unique case (state_r)
      gre_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_row_r;
        wr_data = '0;
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == AW'(MAP_DIM - 1)) begin
          state_nxt = gre_pkg::ST_IDLE;
        end
      end
      gre_pkg::ST_IDLE: begin
        if (start) begin
          if (in_command == gre_pkg::CMD_WRITE) begin
            wx_nxt    = tile_xc[AW-1:0];
            wy_nxt    = tile_yc[AW-1:0];
            wwall_nxt = in_tile_wall;
            rd_en     = 1'b1;
            rd_addr   = tile_yc[AW-1:0];
            if (!tile_out) begin
              state_nxt = gre_pkg::ST_WR;
            end
          end else begin
            ix_nxt    = in_ix;
            iy_nxt    = in_iy;
            fx_nxt    = oxe[F-1:0];
            fy_nxt    = oye[F-1:0];
            xzero_nxt = (in_dir_x == '0);
            yzero_nxt = (in_dir_y == '0);
            xneg_nxt  = in_dir_x[DRW-1];
            yneg_nxt  = in_dir_y[DRW-1];
            magx_nxt  = in_dir_x[DRW-1] ? DRW'(0) - in_dir_x : in_dir_x;
            magy_nxt  = in_dir_y[DRW-1] ? DRW'(0) - in_dir_y : in_dir_y;
            limit_nxt = in_min_distance;
            phase_nxt = 2'd0;
            // origin row is fetched now and held until the divisions end
            rd_en     = 1'b1;
            rd_addr   = in_iy[AW-1:0];
            state_nxt = gre_pkg::ST_DIV_GO;
          end
        end
      end
      gre_pkg::ST_WR: begin
        wr_en     = 1'b1;
        state_nxt = gre_pkg::ST_IDLE;
      end
      gre_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = gre_pkg::ST_DIV_WAIT;
      end
      gre_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          unique case (phase_r)
            2'd0:    dx_nxt = (div_q == '0) ? TW'(1) : q_ext;
            2'd1:    tx_nxt = q_ext;
            2'd2:    dy_nxt = (div_q == '0) ? TW'(1) : q_ext;
            default: ty_nxt = q_ext;
          endcase
          phase_nxt = phase_r + 1'b1;
          state_nxt = (phase_r == 2'd3) ? gre_pkg::ST_ORG : gre_pkg::ST_DIV_GO;
        end
      end
      gre_pkg::ST_ORG: begin
        prevblk_nxt = cur_blk;
        state_nxt   = gre_pkg::ST_STEP;
      end
      gre_pkg::ST_STEP: begin
        if (sat) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = gre_pkg::SAT_DIST;
          state_nxt     = gre_pkg::ST_IDLE;
        end else begin
          ix_nxt    = new_ix;
          iy_nxt    = new_iy;
          m_nxt     = m_c;
          xax_nxt   = xaxis;
          rd_en     = 1'b1;
          rd_addr   = new_iy[AW-1:0];
          state_nxt = gre_pkg::ST_LOOK;
        end
      end
      gre_pkg::ST_LOOK: begin
        if ((m_r > {{(TW-gre_pkg::DIST_W){1'b0}}, limit_r})
            && (cur_out || (cur_blk && !prevblk_r))) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = m_r[gre_pkg::DIST_W-1:0];
          state_nxt     = gre_pkg::ST_IDLE;
        end else begin
          prevblk_nxt = cur_blk;
          if (xax_r) begin
            tx_nxt = tx_r + dx_r;
          end else begin
            ty_nxt = ty_r + dy_r;
          end
          state_nxt = gre_pkg::ST_STEP;
        end
      end
      default: state_nxt = gre_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gre_pkg::ST_CLEAR;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
      map_w_r     <= gre_pkg::CFG_W'(49);
      map_h_r     <= gre_pkg::CFG_W'(49);
      phase_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          gre_pkg::REG_MAP_WIDTH:  map_w_r <= cfg_data;
          gre_pkg::REG_MAP_HEIGHT: map_h_r <= cfg_data;
          default: ;
        endcase
      end
    end
    wx_r       <= wx_nxt;
    wy_r       <= wy_nxt;
    wwall_r    <= wwall_nxt;
    ix_r       <= ix_nxt;
    iy_r       <= iy_nxt;
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    magx_r     <= magx_nxt;
    magy_r     <= magy_nxt;
    xneg_r     <= xneg_nxt;
    yneg_r     <= yneg_nxt;
    xzero_r    <= xzero_nxt;
    yzero_r    <= yzero_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    m_r        <= m_nxt;
    xax_r      <= xax_nxt;
    limit_r    <= limit_nxt;
    prevblk_r  <= prevblk_nxt;
    out_dist_r <= out_dist_nxt;
  end

  assign busy             = (state_r != gre_pkg::ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_hit_distance = out_dist_r;

endmodule

// ===== dv/grid_ray_wall_traversal_test.sv =====
// Self-checking testbench for grid_ray_wall_traversal: tile writes, ray casts, map size changes.
// Predicts hit distances with a DDA walk over a mirrored wall map; depends on gre_pkg and the RTL.
module grid_ray_wall_traversal_test;

  localparam int MAP_DIM   = 64;
  localparam int FRAC_BITS = 16;
  localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
  localparam longint unsigned INF_Q = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint CYCLE_LIMIT = 64'd10_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = gre_pkg::CMD_WRITE;
  logic [gre_pkg::TILE_W-1:0] in_tile_x = '0, in_tile_y = '0;
  logic in_tile_wall = 1'b0;
  logic [gre_pkg::ORG_W-1:0] in_origin_x = '0, in_origin_y = '0;
  logic signed [gre_pkg::DIR_W-1:0] in_dir_x = '0, in_dir_y = '0;
  logic [gre_pkg::DIST_W-1:0] in_min_distance = '0;
  logic out_valid;
  logic [gre_pkg::DIST_W-1:0] out_hit_distance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = gre_pkg::REG_MAP_WIDTH;
  logic [gre_pkg::CFG_W-1:0] cfg_data = '0;

  grid_ray_wall_traversal #(.MAP_DIM(MAP_DIM), .FRAC_BITS(FRAC_BITS)) i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic                       command;
    logic [gre_pkg::TILE_W-1:0] tile_x;
    logic [gre_pkg::TILE_W-1:0] tile_y;
    logic                       tile_wall;
    logic [gre_pkg::ORG_W-1:0]  origin_x;
    logic [gre_pkg::ORG_W-1:0]  origin_y;
    logic [gre_pkg::DIR_W-1:0]  dir_x;
    logic [gre_pkg::DIR_W-1:0]  dir_y;
    logic [gre_pkg::DIST_W-1:0] min_distance;
  } ray_cmd_t;

  // directed row: item, whether a typed-in distance applies, and that distance
  typedef struct {
    ray_cmd_t                   cmd;
    bit                         fixed;
    logic [gre_pkg::DIST_W-1:0] exp_dist;
  } directed_row_t;

  bit                         wall_copy [MAP_DIM*MAP_DIM];
  int unsigned                width_q, height_q;
  logic [gre_pkg::DIST_W-1:0] pending_hits [$];
  int                         fail_count = 0;
  longint                     cycle_count = 0;

  function automatic int eff_dim(int unsigned v);
    return (v > MAP_DIM) ? MAP_DIM : int'(v);
  endfunction

  function automatic bit off_map(longint x, longint y);
    return x < 0 || y < 0 || x >= eff_dim(width_q) || y >= eff_dim(height_q);
  endfunction

  function automatic bit is_solid(longint x, longint y);
    if (off_map(x, y)) return 1'b1;
    return wall_copy[y*MAP_DIM + x];
  endfunction

  function automatic void axis_params(input logic [gre_pkg::DIR_W-1:0] raw,
                                      input longint unsigned frac,
                                      output int stp, output longint unsigned dlt,
                                      output longint unsigned first);
    longint unsigned mag;
    if (raw == 0) begin
      stp = 0; dlt = INF_Q; first = INF_Q;
      return;
    end
    if (raw[gre_pkg::DIR_W-1]) begin
      stp = -1; mag = 64'h80000 - raw;
    end else begin
      stp = 1; mag = raw;
    end
    dlt = (ONE_Q * ONE_Q) / mag;
    if (dlt == 0) dlt = 1;
    first = (stp > 0) ? ((ONE_Q - frac) * ONE_Q) / mag : (frac * ONE_Q) / mag;
  endfunction

  function automatic logic [gre_pkg::DIST_W-1:0] trace_ray(ray_cmd_t c);
    longint ix, iy, px, py;
    int sx, sy;
    longint unsigned dx, dy, tx, ty, m;
    bit xstep;
    ix = c.origin_x >> FRAC_BITS;
    iy = c.origin_y >> FRAC_BITS;
    axis_params(c.dir_x, c.origin_x & (ONE_Q-1), sx, dx, tx);
    axis_params(c.dir_y, c.origin_y & (ONE_Q-1), sy, dy, ty);
    forever begin
      m = (tx < ty) ? tx : ty;
      if (m >= gre_pkg::SAT_DIST) return gre_pkg::SAT_DIST;
      px = ix; py = iy;
      xstep = (sy == 0) || (tx < ty);
      if (xstep) ix += sx; else iy += sy;
      if (m > c.min_distance && (off_map(ix, iy) || (is_solid(ix, iy) && !is_solid(px, py))))
        return m[gre_pkg::DIST_W-1:0];
      if (xstep) tx += dx; else ty += dy;
    end
  endfunction

  // applies the item to the mirrored map and queues any expected hit
  function automatic void predict_item(ray_cmd_t c);
    if (c.command == gre_pkg::CMD_WRITE) begin
      if (!off_map(c.tile_x, c.tile_y)) wall_copy[c.tile_y*MAP_DIM + c.tile_x] = c.tile_wall;
    end else begin
      pending_hits.push_back(trace_ray(c));
    end
  endfunction

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // start stays high into the next item when there is no gap
  task automatic send_item(ray_cmd_t c);
    int gap;
    gap = $urandom_range(0, 14);
    if (gap != 0) begin
      start <= 1'b0;
      wait_cycles(gap);
    end
    start        <= 1'b1;
    in_command   <= c.command;
    in_tile_x    <= c.tile_x;
    in_tile_y    <= c.tile_y;
    in_tile_wall <= c.tile_wall;
    in_origin_x  <= c.origin_x;
    in_origin_y  <= c.origin_y;
    in_dir_x     <= c.dir_x;
    in_dir_y     <= c.dir_y;
    in_min_distance <= c.min_distance;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(c);
  endtask

  // waits out all expected hits, then the longest tile write tail
  task automatic drain();
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    wait_cycles(4);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [gre_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == gre_pkg::REG_MAP_WIDTH) width_q = val; else height_q = val;
    @(posedge clk);
  endtask

  function automatic ray_cmd_t tile_cmd(int x, int y, bit w);
    ray_cmd_t c = '0;
    c.command = gre_pkg::CMD_WRITE;
    c.tile_x = gre_pkg::TILE_W'(x); c.tile_y = gre_pkg::TILE_W'(y); c.tile_wall = w;
    return c;
  endfunction

  function automatic ray_cmd_t cast_cmd(int ox, int oy, int dx, int dy, int md);
    ray_cmd_t c = '0;
    c.command = gre_pkg::CMD_CAST;
    c.origin_x = gre_pkg::ORG_W'(ox); c.origin_y = gre_pkg::ORG_W'(oy);
    c.dir_x = gre_pkg::DIR_W'(dx); c.dir_y = gre_pkg::DIR_W'(dy);
    c.min_distance = gre_pkg::DIST_W'(md);
    return c;
  endfunction

  function automatic ray_cmd_t random_cast(int dim);
    ray_cmd_t c;
    int lim;
    c = cast_cmd(0, 0, 0, 0, 0);
    lim = (dim > 0) ? dim : 1;
    if ($urandom_range(0, 9) == 0) begin
      c.origin_x = gre_pkg::ORG_W'($urandom); c.origin_y = gre_pkg::ORG_W'($urandom);
    end else begin
      c.origin_x = gre_pkg::ORG_W'(($urandom_range(0, lim-1) << FRAC_BITS)
                                   | $urandom_range(0, 65535));
      c.origin_y = gre_pkg::ORG_W'(($urandom_range(0, lim-1) << FRAC_BITS)
                                   | $urandom_range(0, 65535));
    end
    case ($urandom_range(0, 7))
      0: c.dir_x = 0;
      1: c.dir_y = 0;
      default: begin
        c.dir_x = gre_pkg::DIR_W'($urandom); c.dir_y = gre_pkg::DIR_W'($urandom);
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      c.dir_x = $signed(c.dir_x) >>> $urandom_range(0, 12);
      c.dir_y = $signed(c.dir_y) >>> $urandom_range(0, 12);
    end
    case ($urandom_range(0, 5))
      0: c.min_distance = gre_pkg::DIST_W'($urandom);
      1: c.min_distance = gre_pkg::DIST_W'($urandom_range(0, 20) << FRAC_BITS);
      default: c.min_distance = 0;
    endcase
    // a handful of stray tile bits keep every tile field toggling on casts too
    c.tile_x = gre_pkg::TILE_W'($urandom);
    c.tile_y = gre_pkg::TILE_W'($urandom);
    c.tile_wall = 1'($urandom);
    return c;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected hit_distance result 0x%06h", out_hit_distance);
        fail_count++;
      end else begin
        logic [gre_pkg::DIST_W-1:0] exp_d;
        exp_d = pending_hits.pop_front();
        if (out_hit_distance !== exp_d) begin
          $error("hit_distance: expected 0x%06h, actual 0x%06h", exp_d, out_hit_distance);
          fail_count++;
        end
      end
    end
  end

  directed_row_t directed [$];

  initial begin
    ray_cmd_t c;
    int dim;
    for (int i = 0; i < MAP_DIM*MAP_DIM; i++) wall_copy[i] = 1'b0;
    width_q = 49; height_q = 49;
    wait_cycles(8);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // zero direction saturates; a half-cell right from 48.5 leaves the map at 0.5
    directed.push_back('{cast_cmd(0, 0, 0, 0, 0), 1, gre_pkg::SAT_DIST});
    directed.push_back('{cast_cmd(48<<16 | 32768, 5<<16, 65536, 0, 0), 1, 24'h008000});
    directed.push_back('{cast_cmd(0, 0, 65536, 0, 24'hFFFFFF), 1, gre_pkg::SAT_DIST});
    directed.push_back('{tile_cmd(10, 3, 1), 0, '0});
    directed.push_back('{tile_cmd(63, 63, 1), 0, '0});
    directed.push_back('{tile_cmd(0, 0, 1), 0, '0});
    directed.push_back('{cast_cmd(2<<16, 3<<16 | 32768, 65536, 0, 0), 0, '0});
    directed.push_back('{cast_cmd(2<<16, 3<<16, 65536, 65536, 0), 0, '0});
    directed.push_back('{cast_cmd(0, 0, -262144, 262143, 0), 0, '0});
    directed.push_back('{cast_cmd(4194303, 4194303, 1, -1, 0), 0, '0});
    directed.push_back('{cast_cmd(32768, 32768, 0, -65536, 0), 0, '0});
    directed.push_back('{cast_cmd(20<<16, 3<<16 | 32768, -65536, 0, 2<<16), 0, '0});
    directed.push_back('{cast_cmd(4194303, 0, 262143, -262144, 1), 0, '0});
    directed.push_back('{tile_cmd(10, 3, 0), 0, '0});
    directed.push_back('{tile_cmd(0, 0, 0), 0, '0});
    foreach (directed[i]) begin
      send_item(directed[i].cmd);
      if (directed[i].fixed && pending_hits[$] !== directed[i].exp_dist) begin
        $error("hit_distance: table expects 0x%06h, model gives 0x%06h",
               directed[i].exp_dist, pending_hits[$]);
        fail_count++;
      end
    end
    drain();

    // map size phases, extremes first; each mixes wall writes and casts
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(gre_pkg::REG_MAP_WIDTH, gre_pkg::CFG_W'(1));
          write_reg(gre_pkg::REG_MAP_HEIGHT, gre_pkg::CFG_W'(1));
        end
        1: begin
          write_reg(gre_pkg::REG_MAP_WIDTH, gre_pkg::CFG_W'(127));
          write_reg(gre_pkg::REG_MAP_HEIGHT, gre_pkg::CFG_W'(127));
        end
        2: begin
          write_reg(gre_pkg::REG_MAP_WIDTH, gre_pkg::CFG_W'(64));
          write_reg(gre_pkg::REG_MAP_HEIGHT, gre_pkg::CFG_W'(8));
        end
        default: begin
          write_reg(gre_pkg::REG_MAP_WIDTH, gre_pkg::CFG_W'($urandom_range(1, 127)));
          write_reg(gre_pkg::REG_MAP_HEIGHT, gre_pkg::CFG_W'($urandom_range(1, 127)));
        end
      endcase
      dim = eff_dim(width_q > height_q ? width_q : height_q);
      for (int n = 0; n < 66; n++) begin
        if ($urandom_range(0, 2) == 0) begin
          c = random_cast(dim);
          c.command = gre_pkg::CMD_WRITE;
          c.tile_wall = ($urandom_range(0, 2) != 0);
          if ($urandom_range(0, 4) != 0) begin
            c.tile_x = gre_pkg::TILE_W'($urandom_range(0, dim-1));
            c.tile_y = gre_pkg::TILE_W'($urandom_range(0, dim-1));
          end
        end else begin
          c = random_cast(dim);
        end
        send_item(c);
        if (n == 33) drain();
      end
      drain();
    end

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
